// ===== rtl/polyline_length_3d_top_macros.svh =====
// Assertion macros for the 3D polyline length block.
// Included by the top level; no other dependencies.
`ifndef POLYLINE_LENGTH_3D_TOP_MACROS_SVH
`define POLYLINE_LENGTH_3D_TOP_MACROS_SVH

// Condition cons must hold in the same cycle as ante.
`define PL3D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition cons must hold in the cycle after ante.
`define PL3D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pl3d_pkg.sv =====
// Shared constants for the 3D polyline length block.
// No dependencies.
package pl3d_pkg;

	// Default coordinate width, two's complement.
	localparam int PL3D_COORD_BITS = 24;

	// Width of the running length and of the entered length.
	localparam int PL3D_LEN_W = 32;

	// Control state codes of the top-level sequencer.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ   = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

endpackage

// ===== rtl/pl3d_sqsum.sv =====
// Sum of squared coordinate differences, one axis per cycle through a shared multiplier.
// Depends on pl3d_pkg.
module pl3d_sqsum import pl3d_pkg::*; #(
	parameter int COORD_BITS = PL3D_COORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COORD_BITS-1:0]       ax,
	input  logic [COORD_BITS-1:0]       ay,
	input  logic [COORD_BITS-1:0]       az,
	input  logic [COORD_BITS-1:0]       bx,
	input  logic [COORD_BITS-1:0]       by,
	input  logic [COORD_BITS-1:0]       bz,
	output logic                        done,
	output logic [2*COORD_BITS+1:0]     sum
);

	localparam int SQ_W   = 2*COORD_BITS + 2;
	localparam int PROD_W = 2*COORD_BITS;
	localparam logic [1:0] LAST_STEP = 2'd3;

	logic [COORD_BITS-1:0] mag_q [3];
	logic [PROD_W-1:0]     prod_q;
	logic [SQ_W-1:0]       acc_q;
	logic [1:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;

	// Magnitude of the difference of two signed coordinates.
	function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
							   input logic [COORD_BITS-1:0] b);
		logic [COORD_BITS:0] d;
		logic [COORD_BITS:0] n;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		n = ~d + (COORD_BITS+1)'(1);
		return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
	endfunction

	// Sequencing: one axis enters the multiplier per step; the adder takes the registered product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Data path: magnitudes shift through a short shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q[0] <= abs_diff(ax, bx);
			mag_q[1] <= abs_diff(ay, by);
			mag_q[2] <= abs_diff(az, bz);
			acc_q    <= '0;
		end else if (busy_q) begin
			prod_q   <= mag_q[0] * mag_q[0];
			mag_q[0] <= mag_q[1];
			mag_q[1] <= mag_q[2];
			if (cnt_q != 2'd0) begin
				acc_q <= acc_q + SQ_W'(prod_q);
			end
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

// ===== rtl/pl3d_sqrt.sv =====
// Restoring integer square root, two radicand bits in and one root bit out per cycle.
// Depends on pl3d_pkg.
module pl3d_sqrt import pl3d_pkg::*; #(
	parameter int ROOT_W = PL3D_COORD_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int RAD_W = 2*ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int TRY_W = REM_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TRY_W-1:0]  part;
	logic [TRY_W-1:0]  trial;
	logic [TRY_W-1:0]  diff;
	logic              fits;

	// One digit step: bring down two bits and try the next root bit.
	always_comb begin
		part  = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = TRY_W'({root_q, 2'b01});
		fits  = (part >= trial);
		diff  = part - trial;
	end

	// Iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Radicand, partial remainder and root shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? diff[REM_W-1:0] : part[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/polyline_length_3d_top.sv =====
// Top level of the 3D polyline length block: sequencer, vertex and sum state, result register.
// Depends on pl3d_pkg, pl3d_sqsum, pl3d_sqrt and polyline_length_3d_top_macros.svh.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  px, py, pz, first_point, last_point, entered_length
// out      output     out_valid / out_stall projected_length, effective_length, overflow
//
// A vertex that is not a first point passes through the shared squaring multiplier, then the
// bit-serial root, then hand-over, the saturating add in the final step and the return to idle.
// A first point goes straight from idle to the final step and back.
// Reset clears the previous vertex, the sum, the flag and all control state; no clearing pass.
// A vertex is taken only in idle. A last point waits in the final step while a stalled result is
// still held on the output; the output register lets the next vertex in once it is loaded.
`include "polyline_length_3d_top_macros.svh"

module polyline_length_3d_top import pl3d_pkg::*; #(
	parameter int COORD_BITS = PL3D_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COORD_BITS-1:0] pz,
	input  logic                  first_point,
	input  logic                  last_point,
	input  logic [PL3D_LEN_W-1:0] entered_length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PL3D_LEN_W-1:0] projected_length,
	output logic [PL3D_LEN_W-1:0] effective_length,
	output logic                  overflow
);

	localparam int ROOT_W = COORD_BITS + 1;
	localparam int SQ_W   = 2*COORD_BITS + 2;

	logic [1:0]            state_q;
	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic [COORD_BITS-1:0] prev_z_q;
	logic [PL3D_LEN_W-1:0] sum_q;
	logic                  sat_q;
	logic                  first_q;
	logic                  last_q;
	logic [PL3D_LEN_W-1:0] entered_q;

	logic                  out_valid_q;
	logic [PL3D_LEN_W-1:0] proj_q;
	logic [PL3D_LEN_W-1:0] eff_q;
	logic                  ovf_q;

	logic                  in_take;
	logic                  out_free;
	logic                  fin_go;
	logic                  seg_done;
	logic [SQ_W-1:0]       seg_sq;
	logic                  root_done;
	logic [ROOT_W-1:0]     seg_len;
	logic [PL3D_LEN_W:0]   total;
	logic [PL3D_LEN_W-1:0] sum_next;
	logic                  sat_next;

	// Handshake decisions.
	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && (!last_q || out_free);
	assign in_stall = (state_q != ST_IDLE);

	// Squared distance to the previous vertex.
	pl3d_sqsum #(
		.COORD_BITS(COORD_BITS)
	) u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_take && !first_point),
		.ax     (px),
		.ay     (py),
		.az     (pz),
		.bx     (prev_x_q),
		.by     (prev_y_q),
		.bz     (prev_z_q),
		.done   (seg_done),
		.sum    (seg_sq)
	);

	// Segment length as the floor of the root.
	pl3d_sqrt #(
		.ROOT_W(ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_SQ) && seg_done),
		.radicand (seg_sq),
		.done     (root_done),
		.root     (seg_len)
	);

	// Saturating update of the running length; a first point restarts it.
	always_comb begin
		total = {1'b0, sum_q} + (PL3D_LEN_W+1)'(seg_len);
		if (first_q) begin
			sum_next = '0;
			sat_next = 1'b0;
		end else if (total[PL3D_LEN_W]) begin
			sum_next = '1;
			sat_next = 1'b1;
		end else begin
			sum_next = total[PL3D_LEN_W-1:0];
			sat_next = sat_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= first_point ? ST_FIN : ST_SQ;
					end
				end
				ST_SQ: begin
					if (seg_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Previous vertex, running sum and saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			sum_q    <= '0;
			sat_q    <= 1'b0;
		end else begin
			if (in_take) begin
				prev_x_q <= px;
				prev_y_q <= py;
				prev_z_q <= pz;
			end
			if (fin_go) begin
				sum_q <= sum_next;
				sat_q <= sat_next;
			end
		end
	end

	// Item markers and entered length held for the final step.
	always_ff @(posedge clk) begin
		if (in_take) begin
			first_q   <= first_point;
			last_q    <= last_point;
			entered_q <= entered_length;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go && last_q) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fin_go && last_q) begin
			proj_q <= sum_next;
			eff_q  <= (entered_q != '0) ? entered_q : sum_next;
			ovf_q  <= sat_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign projected_length = proj_q;
	assign effective_length = eff_q;
	assign overflow         = ovf_q;

	// Checks on the sequencing and the saturation path.
	`PL3D_ASSERT_NOW(a_out_from_fin, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_FIN, "result loaded outside the final step")
	`PL3D_ASSERT_NOW(a_sq_done_in_sq, clk, arst_n, seg_done,
		state_q == ST_SQ, "squared sum finished outside its step")
	`PL3D_ASSERT_NOW(a_root_done_in_root, clk, arst_n, root_done,
		state_q == ST_ROOT, "root finished outside its step")
	`PL3D_ASSERT_NEXT(a_sat_full, clk, arst_n, fin_go && sat_next,
		sum_q == '1, "saturated sum not at full scale")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the 3D polyline length block (polyline_length_3d_top).
// Depends on pl3d_pkg for the coordinate and length widths; stimulus and prediction are local.
// Directed vertices come from a table, then random polylines are checked against a local predictor.
module tb_top import pl3d_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW          = PL3D_COORD_BITS;
	localparam int LW          = PL3D_LEN_W;
	localparam int ITEMS       = 1300;
	localparam int IDLE_PCT    = 27;
	localparam int HOLD_CYCLES = 500;
	localparam int DRAIN       = 40;
	localparam int WATCHDOG    = 4000;

	localparam logic [CW-1:0] CMAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN  = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] CZERO = '0;
	localparam logic [CW-1:0] CONES = '1;
	localparam logic [LW-1:0] LMAX  = '1;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          first;
		logic          last;
		logic [LW-1:0] entered;
	} vertex_t;

	typedef struct packed {
		logic [LW-1:0] projected;
		logic [LW-1:0] effective;
		logic          ovf;
	} length_res_t;

	typedef struct packed {
		vertex_t     v;
		logic        typed;
		length_res_t r;
	} dir_row_t;

	localparam int DIR_ROWS = 18;

	// Directed vertices; typed results only where they are obvious at a glance.
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		// No first point after reset: measured from the origin.
		'{'{CZERO, CZERO, CZERO, 1'b0, 1'b1, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b0}},
		'{'{24'd48, 24'd64, CZERO, 1'b0, 1'b1, 32'd0}, 1'b1, '{32'd80, 32'd80, 1'b0}},
		// One-point polyline with the largest entered length.
		'{'{CMAX, CMAX, CMAX, 1'b1, 1'b1, LMAX}, 1'b1, '{32'd0, LMAX, 1'b0}},
		// Corner to corner segments.
		'{'{CMIN, CMIN, CMIN, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{CMAX, CMAX, CMAX, 1'b0, 1'b0, 32'd0}, 1'b0, '0},
		'{'{CMIN, CMAX, CMIN, 1'b0, 1'b1, 32'd0}, 1'b0, '0},
		// Unit diagonal: the root rounds down to one.
		'{'{CZERO, CZERO, CZERO, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{CONES, CONES, CONES, 1'b0, 1'b1, 32'd1}, 1'b1, '{32'd1, 32'd1, 1'b0}},
		// A repeated first point drops the earlier vertex.
		'{'{24'd5, 24'd5, 24'd5, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{24'd100, CZERO, CZERO, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{24'd100, CZERO, 24'hFFFED4, 1'b0, 1'b1, 32'd0}, 1'b1, '{32'd300, 32'd300, 1'b0}},
		// Full span along one axis.
		'{'{CMIN, CZERO, CZERO, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{CMAX, CZERO, CZERO, 1'b0, 1'b1, 32'd0}, 1'b1, '{32'hFFFFFF, 32'hFFFFFF, 1'b0}},
		'{'{CZERO, CMIN, CZERO, 1'b0, 1'b1, 32'h80000000}, 1'b0, '0},
		// Zero-length segment.
		'{'{CZERO, CZERO, CMAX, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{CZERO, CZERO, CMAX, 1'b0, 1'b1, 32'd0}, 1'b1, '{32'd0, 32'd0, 1'b0}},
		// Alternating bit patterns.
		'{'{24'h555555, 24'hAAAAAA, 24'h5A5A5A, 1'b1, 1'b0, 32'd0}, 1'b0, '0},
		'{'{24'hAAAAAA, 24'h555555, 24'hA5A5A5, 1'b0, 1'b1, 32'h12345678}, 1'b0, '0}
	};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [CW-1:0] px = '0;
	logic [CW-1:0] py = '0;
	logic [CW-1:0] pz = '0;
	logic          first_point = 1'b0;
	logic          last_point = 1'b0;
	logic [LW-1:0] entered_length = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [LW-1:0] projected_length;
	logic [LW-1:0] effective_length;
	logic          overflow;

	// Predictor state: previous vertex, running sum and sticky saturation flag.
	logic [CW-1:0] last_x = '0;
	logic [CW-1:0] last_y = '0;
	logic [CW-1:0] last_z = '0;
	logic [LW-1:0] run_sum = '0;
	logic          run_sat = 1'b0;

	length_res_t expected_lengths [$];
	vertex_t     vertex_q [$];
	int          sent = 0;
	int          sat_runs = 0;
	int          results_seen = 0;
	int          fail_cnt = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;

	polyline_length_3d_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.px               (px),
		.py               (py),
		.pz               (pz),
		.first_point      (first_point),
		.last_point       (last_point),
		.entered_length   (entered_length),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.projected_length (projected_length),
		.effective_length (effective_length),
		.overflow         (overflow)
	);

	// Clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Floor of the square root, one result bit per pass.
	function automatic logic [63:0] floor_root(input logic [63:0] val);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem  = val;
		root = '0;
		b    = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// Advance the polyline state by one vertex; returns 1 when a result is due.
	function automatic bit polyline_advance(input vertex_t v, output length_res_t r);
		longint      dx;
		longint      dy;
		longint      dz;
		logic [63:0] seg;
		logic [63:0] total;
		if (v.first) begin
			run_sum = '0;
			run_sat = 1'b0;
		end else begin
			dx = longint'($signed(v.x)) - longint'($signed(last_x));
			dy = longint'($signed(v.y)) - longint'($signed(last_y));
			dz = longint'($signed(v.z)) - longint'($signed(last_z));
			seg = floor_root(64'(dx * dx + dy * dy + dz * dz));
			total = 64'(run_sum) + seg;
			if (total > 64'(LMAX)) begin
				run_sum = LMAX;
				run_sat = 1'b1;
			end else begin
				run_sum = total[LW-1:0];
			end
		end
		last_x = v.x;
		last_y = v.y;
		last_z = v.z;
		r.projected = run_sum;
		r.effective = (v.entered != 0) ? v.entered : run_sum;
		r.ovf       = run_sat;
		return v.last;
	endfunction

	// Next coordinate: fully random, a short step from the previous one, or an extreme.
	function automatic logic [CW-1:0] next_coord(input logic [CW-1:0] p);
		int m;
		m = $urandom_range(9);
		if (m < 4)
			return CW'($urandom);
		if (m < 7)
			return p + CW'($urandom_range(4095)) - CW'(2048);
		case ($urandom_range(3))
			0: return CMIN;
			1: return CMAX;
			2: return CZERO;
			default: return CONES;
		endcase
	endfunction

	function automatic logic [LW-1:0] rand_entered();
		int m;
		m = $urandom_range(99);
		if (m < 50)
			return '0;
		if (m < 65)
			return LMAX;
		if (m < 75)
			return 32'd1;
		return $urandom;
	endfunction

	// Queue up the next random polyline.
	task automatic plan_polyline();
		int      pick;
		int      n;
		vertex_t v;
		pick = $urandom_range(99);
		v.x = CW'($urandom);
		v.y = CW'($urandom);
		v.z = CW'($urandom);
		if (sat_runs < 3 && sent >= 350 * (sat_runs + 1)) begin
			// Long run between opposite corners, enough to saturate the sum.
			n = 150 + $urandom_range(15);
			for (int i = 0; i <= n + 1; i++) begin
				v.x       = (i % 2) ? CMAX : CMIN;
				v.y       = (i % 2) ? CMIN : CMAX;
				v.z       = (i % 2) ? CMAX : CMIN;
				v.first   = (i == 0);
				v.last    = (i == n + 1);
				v.entered = (v.last && sat_runs != 1) ? '0 : $urandom;
				vertex_q.insert(vertex_q.size(), v);
			end
			sat_runs++;
		end else if (pick < 75) begin
			// Well-formed polyline: first point, a few internal points, last point.
			n = $urandom_range(7);
			for (int i = 0; i <= n + 1; i++) begin
				v.x       = next_coord(v.x);
				v.y       = next_coord(v.y);
				v.z       = next_coord(v.z);
				v.first   = (i == 0);
				v.last    = (i == n + 1);
				v.entered = v.last ? rand_entered() : $urandom;
				vertex_q.insert(vertex_q.size(), v);
			end
		end else begin
			// Noise: markers set at random, including first and last together.
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				v.x       = next_coord(v.x);
				v.y       = next_coord(v.y);
				v.z       = next_coord(v.z);
				v.first   = $urandom_range(1);
				v.last    = $urandom_range(1);
				v.entered = rand_entered();
				vertex_q.insert(vertex_q.size(), v);
			end
		end
	endtask

	// Offer one vertex, wait for it to be taken, then record what it should produce.
	task automatic drive_vertex(input vertex_t v, input bit typed, input length_res_t typed_res);
		length_res_t r;
		calm = (sent >= 500 && sent < 700);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		px             <= v.x;
		py             <= v.y;
		pz             <= v.z;
		first_point    <= v.first;
		last_point     <= v.last;
		entered_length <= v.entered;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (polyline_advance(v, r))
			expected_lengths.insert(expected_lengths.size(), typed ? typed_res : r);
	endtask

	// Compare one taken result with the oldest expectation.
	task automatic check_result();
		length_res_t e;
		results_seen++;
		if (expected_lengths.size() == 0) begin
			if (fail_cnt < 10)
				$display("unexpected result: proj %h eff %h ovf %b",
					projected_length, effective_length, overflow);
			fail_cnt++;
		end else begin
			e = expected_lengths.pop_front();
			if (projected_length !== e.projected || effective_length !== e.effective ||
					overflow !== e.ovf) begin
				if (fail_cnt < 10)
					$display("mismatch: proj %h/%h eff %h/%h ovf %b/%b (expected/actual)",
						e.projected, projected_length, e.effective, effective_length,
						e.ovf, overflow);
				fail_cnt++;
			end
		end
	endtask

	// Result side: random stalls, long hold-offs to fill the block up, a calm stretch.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_result();
			if (hold_left == 0 && holds_done < 2 && results_seen >= 25 + 200 * holds_done) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset, directed table, random polylines, drain and verdict.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			drive_vertex(DIR_TAB[i].v, DIR_TAB[i].typed, DIR_TAB[i].r);
		while (sent < ITEMS || vertex_q.size() != 0) begin
			if (vertex_q.size() == 0)
				plan_polyline();
			drive_vertex(vertex_q.pop_front(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (expected_lengths.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_cnt == 0 && expected_lengths.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
